// ===== sv/epcal_pkg.sv =====
package epcal_pkg;

   localparam int unsigned UnitWidth = 32;
   localparam int unsigned MulWidth  = 26;

   localparam logic [MulWidth-1:0] SecsPerDay  = 26'd86400;
   localparam logic [MulWidth-1:0] SecsPerHour = 26'd3600;
   localparam logic [MulWidth-1:0] SecsPerMin  = 26'd60;

   // Reciprocals rounded up, so that (x * recip) >> shift is the exact quotient for every
   // dividend the sequencer can present. The day dividend is the seconds shifted right by
   // seven, since 86400 is 128 * 675.
   localparam logic [MulWidth-1:0] DayRecip  = 26'd50903317;
   localparam logic [MulWidth-1:0] HourRecip = 26'd149131;
   localparam logic [MulWidth-1:0] MinRecip  = 26'd4370;
   localparam int unsigned DayShift  = 35;
   localparam int unsigned HourShift = 29;
   localparam int unsigned MinShift  = 18;

   localparam logic [11:0] BaseYear       = 12'd1970;
   localparam logic [6:0]  BaseYearMod100 = 7'd70;
   localparam logic [8:0]  BaseYearMod400 = 9'd370;
   localparam logic [6:0]  LastMod100     = 7'd99;
   localparam logic [8:0]  LastMod400     = 9'd399;

   localparam logic [8:0] LeapYearLen   = 9'd366;
   localparam logic [8:0] CommonYearLen = 9'd365;

   localparam logic [3:0] MonthJan = 4'd0;
   localparam logic [3:0] MonthFeb = 4'd1;
   localparam logic [3:0] MonthDec = 4'd11;

   // Steps of each division: quotient, back-multiply, remainder.
   localparam logic [1:0] PhaseRecip = 2'd0;
   localparam logic [1:0] PhaseBack  = 2'd1;
   localparam logic [1:0] PhaseSub   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYDIV,
      ST_HOURDIV,
      ST_MINDIV,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   // Month length for a zero-based month index.
   function automatic logic [8:0] month_len(input logic [3:0] m, input logic leap);
      logic [8:0] len;
      case (m)
         4'd0:    len = 9'd31;
         4'd1:    len = leap ? 9'd29 : 9'd28;
         4'd2:    len = 9'd31;
         4'd3:    len = 9'd30;
         4'd4:    len = 9'd31;
         4'd5:    len = 9'd30;
         4'd6:    len = 9'd31;
         4'd7:    len = 9'd31;
         4'd8:    len = 9'd30;
         4'd9:    len = 9'd31;
         4'd10:   len = 9'd30;
         4'd11:   len = 9'd31;
         default: len = 9'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/epcal_if.sv =====
interface epcal_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface epcal_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (
      output valid, output year, output month, output day_of_month,
      output hour, output minute, output second, input ready
   );
   modport sink (
      input valid, input year, input month, input day_of_month,
      input hour, input minute, input second, output ready
   );
endinterface

// ===== sv/epcal_sub_unit.sv =====
module epcal_sub_unit
   import epcal_pkg::*;
(
   input  logic [UnitWidth-1:0] a,
   input  logic [UnitWidth-1:0] b,
   output logic                 ge,
   output logic [UnitWidth-1:0] diff
);

   logic [UnitWidth:0] wide_diff;

   // The borrow out of the subtraction doubles as the compare result.
   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign ge        = ~wide_diff[UnitWidth];
   assign diff      = wide_diff[UnitWidth-1:0];

endmodule

// ===== sv/epcal_core.sv =====
module epcal_core
   import epcal_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [31:0]     epoch_seconds,
   input  logic            take,
   output core_status_type status,
   output result_type      result
);

   state_type state_ff, state_in;

   logic [31:0]          q_ff, q_in;
   logic [UnitWidth-1:0] rem_ff, rem_in;
   logic [31:0]          prod_ff, prod_in;
   logic [1:0]           phase_ff, phase_in;
   logic [15:0]          days_ff, days_in;
   logic [11:0]          year_ff, year_in;
   logic [6:0]           mod100_ff, mod100_in;
   logic [8:0]           mod400_ff, mod400_in;
   logic [3:0]           month_ff, month_in;
   logic [4:0]           hour_ff, hour_in;
   logic [5:0]           minute_ff, minute_in;
   logic [5:0]           second_ff, second_in;

   logic [UnitWidth-1:0]  unit_a, unit_b, unit_diff;
   logic                  unit_ge;
   logic [MulWidth-1:0]   mul_a, mul_b;
   logic [2*MulWidth-1:0] mul_p;
   logic                  leap;
   logic [8:0]            year_len;

   epcal_sub_unit u_sub (
      .a    (unit_a),
      .b    (unit_b),
      .ge   (unit_ge),
      .diff (unit_diff)
   );

   // One multiplier serves every quotient and back-multiply step.
   assign mul_p = {{MulWidth{1'b0}}, mul_a} * {{MulWidth{1'b0}}, mul_b};

   assign leap     = (year_ff[1:0] == 2'b00) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));
   assign year_len = leap ? LeapYearLen : CommonYearLen;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (start) state_in = ST_DAYDIV;
         ST_DAYDIV:  if (phase_ff == PhaseSub) state_in = ST_HOURDIV;
         ST_HOURDIV: if (phase_ff == PhaseSub) state_in = ST_MINDIV;
         ST_MINDIV:  if (phase_ff == PhaseSub) state_in = ST_YEAR;
         ST_YEAR:    if (!unit_ge) state_in = ST_MONTH;
         ST_MONTH:   if (!unit_ge || month_ff == MonthDec) state_in = ST_DONE;
         ST_DONE:    if (take) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_in      = q_ff;
      rem_in    = rem_ff;
      prod_in   = prod_ff;
      phase_in  = phase_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      unit_a    = q_ff;
      unit_b    = prod_ff;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               q_in      = epoch_seconds;
               phase_in  = PhaseRecip;
               year_in   = BaseYear;
               mod100_in = BaseYearMod100;
               mod400_in = BaseYearMod400;
               month_in  = MonthJan;
            end
         end
         ST_DAYDIV: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               PhaseRecip: begin
                  // The low seven bits cannot change the day count.
                  mul_a   = {1'b0, q_ff[31:7]};
                  mul_b   = DayRecip;
                  days_in = mul_p[DayShift +: 16];
               end
               PhaseBack: begin
                  mul_a   = {10'b0, days_ff};
                  mul_b   = SecsPerDay;
                  prod_in = mul_p[31:0];
               end
               default: begin
                  // The seconds of the day become the next dividend.
                  q_in     = unit_diff;
                  phase_in = PhaseRecip;
               end
            endcase
         end
         ST_HOURDIV: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               PhaseRecip: begin
                  mul_a   = {9'b0, q_ff[16:0]};
                  mul_b   = HourRecip;
                  hour_in = mul_p[HourShift +: 5];
               end
               PhaseBack: begin
                  mul_a   = {21'b0, hour_ff};
                  mul_b   = SecsPerHour;
                  prod_in = mul_p[31:0];
               end
               default: begin
                  q_in     = unit_diff;
                  phase_in = PhaseRecip;
               end
            endcase
         end
         ST_MINDIV: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               PhaseRecip: begin
                  mul_a     = {14'b0, q_ff[11:0]};
                  mul_b     = MinRecip;
                  minute_in = mul_p[MinShift +: 6];
               end
               PhaseBack: begin
                  mul_a   = {20'b0, minute_ff};
                  mul_b   = SecsPerMin;
                  prod_in = mul_p[31:0];
               end
               default: begin
                  second_in = unit_diff[5:0];
                  rem_in    = {16'b0, days_ff};
                  phase_in  = PhaseRecip;
               end
            endcase
         end
         ST_YEAR: begin
            unit_a = rem_ff;
            unit_b = {23'b0, year_len};
            if (unit_ge) begin
               rem_in    = unit_diff;
               year_in   = year_ff + 12'd1;
               mod100_in = (mod100_ff == LastMod100) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == LastMod400) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         ST_MONTH: begin
            unit_a = rem_ff;
            unit_b = {23'b0, month_len(month_ff, leap)};
            if (unit_ge && month_ff != MonthDec) begin
               rem_in   = unit_diff;
               month_in = month_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      prod_ff   <= prod_in;
      phase_ff  <= phase_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   // In the done state the running remainder is the zero-based day of the month.
   assign result.year         = year_ff;
   assign result.month        = month_ff + 4'd1;
   assign result.day_of_month = rem_ff[4:0] + 5'd1;
   assign result.hour         = hour_ff;
   assign result.minute       = minute_ff;
   assign result.second       = second_ff;

endmodule

// ===== sv/epoch_seconds_to_calendar_top.sv =====
// A shared multiplier and compare-subtract unit do three reciprocal divisions in nine steps,
// then one step per whole year since 1970 (0 to 136) and per month before the result's
// month (0 to 11); a new beat is taken only once the sequencer is idle again.
// The result register lets the next beat be accepted while a result waits.
// Reset is synchronous and active high; it idles the sequencer and empties the output.
module epoch_seconds_to_calendar_top
   import epcal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   epcal_req_if.sink   req,
   epcal_rsp_if.source rsp
);

   core_status_type status;
   result_type      core_result;
   logic            start;
   logic            take;
   logic            out_free;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign req.ready = status.idle;
   assign start     = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign take      = status.done && out_free;

   epcal_core u_core (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .epoch_seconds (req.epoch_seconds),
      .take          (take),
      .status        (status),
      .result        (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.year         = rsp_data_ff.year;
   assign rsp.month        = rsp_data_ff.month;
   assign rsp.day_of_month = rsp_data_ff.day_of_month;
   assign rsp.hour         = rsp_data_ff.hour;
   assign rsp.minute       = rsp_data_ff.minute;
   assign rsp.second       = rsp_data_ff.second;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("input accepted again while a conversion is running");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.month >= 4'd1 && rsp.month <= 4'd12 &&
                    rsp.day_of_month >= 5'd1 && rsp.year >= 12'd1970 &&
                    rsp.year <= 12'd2106)
      else $error("calendar date out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.hour < 5'd24 && rsp.minute < 6'd60 && rsp.second < 6'd60)
      else $error("time of day out of range");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      status.done && !out_free |=> status.done)
      else $error("result left the sequencer while the output was full");

endmodule

// ===== tb/epoch_seconds_to_calendar_top_tb.sv =====
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top_tb
   import epcal_pkg::*;
();

   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_ITEMS  = 1430;
   localparam int HOLD_AT       = 250;
   localparam int DRAIN_AT      = 700;
   localparam int CALM_AT       = 1250;
   localparam int LONG_HOLD     = 500;
   localparam int TAIL_CYCLES   = 256;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int PRINT_LIMIT   = 40;

   localparam bit KNOWN     = 1'b1;
   localparam bit PREDICTED = 1'b0;
   localparam result_type NO_DATE = '0;

   typedef struct packed {
      logic [31:0] secs;
      bit          known;
      result_type  want;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] secs;
      result_type  want;
   } date_expect_type;

   logic clock;
   logic reset;

   epcal_req_if req_chan ();
   epcal_rsp_if rsp_chan ();

   epoch_seconds_to_calendar_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

   date_expect_type pending_dates[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  hold_request = 1'b0;
   bit  calm_tail = 1'b0;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic bit gregorian_leap(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // Calendar date and time of day for a count of seconds since the epoch.
   function automatic result_type calendar_of_seconds(input logic [31:0] secs);
      result_type  r;
      int unsigned s;
      int unsigned days;
      int unsigned yr;
      int unsigned ylen;
      int unsigned mo;
      int unsigned mlen;
      s    = secs;
      days = s / 86400;
      yr   = 1970;
      ylen = gregorian_leap(yr) ? 366 : 365;
      while (days >= ylen) begin
         days = days - ylen;
         yr   = yr + 1;
         ylen = gregorian_leap(yr) ? 366 : 365;
      end
      // December needs no test: whatever is left falls in it.
      for (mo = 0; mo < 11; mo++) begin
         case (mo)
            1:       mlen = gregorian_leap(yr) ? 29 : 28;
            3, 5, 8, 10: mlen = 30;
            default: mlen = 31;
         endcase
         if (days < mlen) break;
         days = days - mlen;
      end
      r.year         = 12'(yr);
      r.month        = 4'(mo + 1);
      r.day_of_month = 5'(days + 1);
      r.hour         = 5'((s % 86400) / 3600);
      r.minute       = 6'((s % 3600) / 60);
      r.second       = 6'(s % 60);
      return r;
   endfunction

   function automatic result_type date_time(input int unsigned y, input int unsigned mo,
                                            input int unsigned d, input int unsigned h,
                                            input int unsigned mi, input int unsigned s);
      result_type r;
      r.year         = 12'(y);
      r.month        = 4'(mo);
      r.day_of_month = 5'(d);
      r.hour         = 5'(h);
      r.minute       = 6'(mi);
      r.second       = 6'(s);
      return r;
   endfunction

   function automatic stim_row_type directed_row(input int idx);
      stim_row_type row;
      case (idx)
         0:  row = {32'd0,          KNOWN,     date_time(1970, 1, 1, 0, 0, 0)};
         1:  row = {32'd1,          KNOWN,     date_time(1970, 1, 1, 0, 0, 1)};
         2:  row = {32'd59,         KNOWN,     date_time(1970, 1, 1, 0, 0, 59)};
         3:  row = {32'd60,         KNOWN,     date_time(1970, 1, 1, 0, 1, 0)};
         4:  row = {32'd3599,       KNOWN,     date_time(1970, 1, 1, 0, 59, 59)};
         5:  row = {32'd3600,       KNOWN,     date_time(1970, 1, 1, 1, 0, 0)};
         6:  row = {32'd86399,      KNOWN,     date_time(1970, 1, 1, 23, 59, 59)};
         7:  row = {32'd86400,      KNOWN,     date_time(1970, 1, 2, 0, 0, 0)};
         8:  row = {32'd31535999,   PREDICTED, NO_DATE};
         9:  row = {32'd31536000,   KNOWN,     date_time(1971, 1, 1, 0, 0, 0)};
         10: row = {32'd68169600,   PREDICTED, NO_DATE};
         11: row = {32'd951782400,  PREDICTED, NO_DATE};
         12: row = {32'd951868800,  PREDICTED, NO_DATE};
         13: row = {32'h7FFF_FFFF,  KNOWN,     date_time(2038, 1, 19, 3, 14, 7)};
         14: row = {32'h8000_0000,  PREDICTED, NO_DATE};
         15: row = {32'h5555_5555,  PREDICTED, NO_DATE};
         16: row = {32'hAAAA_AAAA,  PREDICTED, NO_DATE};
         17: row = {32'd4107456000, PREDICTED, NO_DATE};
         18: row = {32'd4107542400, PREDICTED, NO_DATE};
         19: row = {32'd4291747200, PREDICTED, NO_DATE};
         20: row = {32'hFFFF_FFFE,  PREDICTED, NO_DATE};
         default: row = {32'hFFFF_FFFF, KNOWN, date_time(2106, 2, 7, 6, 28, 15)};
      endcase
      return row;
   endfunction

   // Holds valid until the beat is taken, then records what it should produce.
   task automatic offer_seconds(input logic [31:0] secs, input result_type want);
      req_chan.valid         <= 1'b1;
      req_chan.epoch_seconds <= secs;
      do @(posedge clock); while (!req_chan.ready);
      pending_dates.push_back({secs, want});
   endtask

   task automatic idle_sender();
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] secs,
                                input logic [11:0] want, input logic [11:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s mismatch for %0d s, expected %0d, actual %0d",
                     $time, field, secs, want, got);
      end
   endtask

   always @(posedge clock) begin : check_dates
      date_expect_type head;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT)
               $display("%0t: result beat with nothing pending, expected none, actual %0d-%0d-%0d",
                        $time, rsp_chan.year, rsp_chan.month, rsp_chan.day_of_month);
         end else begin
            head = pending_dates.pop_front();
            compare_field("year",         head.secs, head.want.year,         rsp_chan.year);
            compare_field("month",        head.secs, 12'(head.want.month),
                          12'(rsp_chan.month));
            compare_field("day_of_month", head.secs, 12'(head.want.day_of_month),
                          12'(rsp_chan.day_of_month));
            compare_field("hour",         head.secs, 12'(head.want.hour),
                          12'(rsp_chan.hour));
            compare_field("minute",       head.secs, 12'(head.want.minute),
                          12'(rsp_chan.minute));
            compare_field("second",       head.secs, 12'(head.want.second),
                          12'(rsp_chan.second));
         end
      end
   end

   initial begin : drain_results
      int pick;
      int k;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            // Long back-pressure: the block fills and must stall its input.
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(posedge clock);
         end else if (calm_tail) begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end else begin
            pick = $urandom_range(0, 15);
            if (pick < 5) begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end else if (pick == 15) begin
               rsp_chan.ready <= 1'b1;
               repeat (150) @(posedge clock);
            end else begin
               rsp_chan.ready <= 1'b1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
   end

   initial begin : feed_seconds
      stim_row_type row;
      logic [31:0]  secs;
      int unsigned  day_pick;
      int unsigned  tod;
      int           n;
      req_chan.valid         <= 1'b0;
      req_chan.epoch_seconds <= '0;
      do @(posedge clock); while (reset);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_row(n);
         offer_seconds(row.secs, row.known ? row.want : calendar_of_seconds(row.secs));
         idle_sender();
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT)
            hold_request = 1'b1;
         if (n == CALM_AT)
            calm_tail = 1'b1;
         if (n == DRAIN_AT) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_dates.size() != 0);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: secs = $urandom;
            5, 6: begin
               // Land on a random day, mostly on or next to a midnight, so year and month edges get hit.
               day_pick = $urandom_range(0, 49709);
               case ($urandom_range(0, 2))
                  0:       tod = 0;
                  1:       tod = 86399;
                  default: tod = $urandom_range(0, 86399);
               endcase
               secs = day_pick * 86400 + tod;
            end
            7:       secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
            default: secs = $urandom_range(0, 200000000);
         endcase
         offer_seconds(secs, calendar_of_seconds(secs));
         idle_sender();
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_dates.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
